// ===== hw/rtl/sbph_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbph_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the spectrum bar meter with peak hold.
// ----------------------------------------------------------------------------
package sbph_pkg;

  localparam int MAX_BARS  = 256;
  localparam int USED_BINS = 256;

  localparam int BIN_W     = 9;
  localparam int MAG_W     = 15;
  localparam int LEVEL_W   = 16;
  localparam int BAR_W     = 8;
  localparam int KLOG_W    = 4;
  localparam int SCALE_W   = 8;
  localparam int BPCT_W    = 8;
  localparam int PPCT_W    = 7;

  // bits of a bin number inside the used range
  localparam int USED_W    = $clog2(USED_BINS);
  localparam int MEM_AW    = $clog2(MAX_BARS);

  localparam logic [KLOG_W-1:0] KLOG_MIN   = KLOG_W'(1);
  localparam logic [KLOG_W-1:0] KLOG_MAX   = KLOG_W'($clog2(MAX_BARS));
  localparam logic [KLOG_W-1:0] KLOG_RST   = KLOG_W'(8);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(255);

  localparam logic [LEVEL_W-1:0] PEAK_DECAY  = LEVEL_W'(255);
  localparam int                 FULL_SCALE  = 32'h7fff;
  localparam logic [PPCT_W-1:0]  PERCENT_CAP = PPCT_W'(100);

  // configuration register indexes
  localparam logic REG_BAR_LOG2 = 1'b0;
  localparam logic REG_SCALE    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_MUL,
    S_EMIT
  } sbph_state_t;

  typedef struct packed {
    logic accept;  // take the input word
    logic read;    // read peak store, form bar level
    logic calc;    // update and write back the peak
    logic mul;     // scale levels by 100
    logic emit;    // load the output register
  } sbph_cmd_t;

  typedef struct packed {
    logic bar_done;  // current input word closes a bar
    logic out_busy;  // output register holds a stalled word
  } sbph_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sbph_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbph_ctrl
// Sequencer: accepts bins, and walks a closing bin through the peak
// read-modify-write and the output load.
// ----------------------------------------------------------------------------
module sbph_ctrl import sbph_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire sbph_stat_t stat,
  output sbph_cmd_t       cmd
);

  sbph_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && stat.bar_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sbph_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbph_datapath
// Group maximum, bar level, peak store with valid bits, percent scaling
// and the output register.
// ----------------------------------------------------------------------------
module sbph_datapath import sbph_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sbph_cmd_t          cmd,
  output sbph_stat_t              stat,
  input  wire logic [KLOG_W-1:0]  bar_log2,
  input  wire logic [SCALE_W-1:0] scale,
  input  wire logic [BIN_W-1:0]   in_bin_index,
  input  wire logic [MAG_W-1:0]   in_magnitude,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [BAR_W-1:0]        out_bar_number,
  output logic [LEVEL_W-1:0]      out_bar_level,
  output logic [LEVEL_W-1:0]      out_peak_level,
  output logic [BPCT_W-1:0]       out_bar_percent,
  output logic [PPCT_W-1:0]       out_peak_percent
);

  localparam int PROD_W = LEVEL_W + 7;

  // y / 32767 for y < 2^PROD_W: start from y >> 15, fix up by one
  function automatic logic [BPCT_W-1:0] pct_div(input logic [PROD_W-1:0] y);
    logic [PROD_W-16:0] q0;
    logic [PROD_W-1:0]  base;
    logic [PROD_W-1:0]  rem;
    q0   = y[PROD_W-1:15];
    base = {q0, 15'd0} - PROD_W'(q0);
    rem  = y - base;
    if (rem >= PROD_W'(FULL_SCALE)) begin
      q0 = q0 + 1'b1;
    end
    return BPCT_W'(q0);
  endfunction

  logic [KLOG_W-1:0]  klog;
  logic [USED_W-1:0]  pos_mask;
  logic [USED_W-1:0]  pos;
  logic [KLOG_W-1:0]  bar_shift;
  logic [USED_W-1:0]  bar_idx;
  logic               bin_used;

  logic [MAG_W-1:0]   gmax_r;
  logic [BAR_W-1:0]   bar_r;
  logic [LEVEL_W-1:0] level_r;
  logic [LEVEL_W-1:0] rd_r;
  logic               rd_vld_r;
  logic [LEVEL_W-1:0] peak_r;
  logic [LEVEL_W-1:0] peak_old;
  logic [LEVEL_W-1:0] peak_nxt;
  logic [PROD_W-1:0]  ybar_r;
  logic [PROD_W-1:0]  ypk_r;
  logic [BPCT_W-1:0]  ppct_full;

  logic [LEVEL_W-1:0] peak_mem [MAX_BARS];
  logic [MAX_BARS-1:0] pv_r;

  logic               out_valid_r;
  logic [BAR_W-1:0]   out_bar_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [LEVEL_W-1:0] out_peak_r;
  logic [BPCT_W-1:0]  out_bpct_r;
  logic [PPCT_W-1:0]  out_ppct_r;

  // bar count clamped to its legal range
  always_comb begin
    klog = bar_log2;
    if (klog < KLOG_MIN) klog = KLOG_MIN;
    if (klog > KLOG_MAX) klog = KLOG_MAX;
  end

  assign pos_mask  = {USED_W{1'b1}} >> klog;
  assign pos       = in_bin_index[USED_W-1:0] & pos_mask;
  assign bar_shift = KLOG_W'(USED_W) - klog;
  assign bar_idx   = in_bin_index[USED_W-1:0] >> bar_shift;
  assign bin_used  = in_bin_index < BIN_W'(USED_BINS);

  assign stat.bar_done = bin_used && (pos == pos_mask) &&
                         ({1'b0, bar_idx} < (USED_W+1)'(MAX_BARS));
  assign stat.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gmax_r <= '0;
    end else if (cmd.accept && bin_used) begin
      if (pos == '0 || in_magnitude > gmax_r) begin
        gmax_r <= in_magnitude;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bar_r <= BAR_W'(bar_idx);
    end
    if (cmd.read) begin
      level_r <= LEVEL_W'(gmax_r * scale);
      rd_r    <= peak_mem[bar_r[MEM_AW-1:0]];
    end
    if (cmd.calc) begin
      peak_mem[bar_r[MEM_AW-1:0]] <= peak_nxt;
      peak_r                      <= peak_nxt;
    end
    if (cmd.mul) begin
      ybar_r <= PROD_W'(level_r) * PROD_W'(100);
      ypk_r  <= PROD_W'(peak_r) * PROD_W'(100);
    end
  end

  // valid bits stand in for the all-zero reset of the peak store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r     <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.read) rd_vld_r <= pv_r[bar_r[MEM_AW-1:0]];
      if (cmd.calc) pv_r[bar_r[MEM_AW-1:0]] <= 1'b1;
    end
  end

  assign peak_old = rd_vld_r ? rd_r : '0;

  always_comb begin
    if (peak_old <= level_r) begin
      peak_nxt = level_r;
    end else if (peak_old > PEAK_DECAY) begin
      peak_nxt = peak_old - PEAK_DECAY;
    end else begin
      peak_nxt = '0;
    end
  end

  assign ppct_full = pct_div(ypk_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bar_r   <= bar_r;
      out_level_r <= level_r;
      out_peak_r  <= peak_r;
      out_bpct_r  <= pct_div(ybar_r);
      out_ppct_r  <= (ppct_full > BPCT_W'(PERCENT_CAP)) ? PERCENT_CAP
                                                        : PPCT_W'(ppct_full);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bar_number   = out_bar_r;
  assign out_bar_level    = out_level_r;
  assign out_peak_level   = out_peak_r;
  assign out_bar_percent  = out_bpct_r;
  assign out_peak_percent = out_ppct_r;

endmodule
`default_nettype wire

// ===== hw/rtl/spectrum_bar_peak_hold_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold_unit
// Spectrum bar meter: per-bar maximum of magnitude bins, gain, peak hold
// with decay, and percent-of-full-scale readouts.
// ----------------------------------------------------------------------------
// Bins stream in as words on the in_ channel, one per cycle while in_stall is
// low, in ascending bin order. Bins below the used range are grouped into
// 2^bar_count_log2 bars (the register is clamped to 1..8); each word either
// just updates the running group maximum or closes a bar. A closing word holds
// in_stall high while the peak store does its read-modify-write: registered
// memory read with the bar level multiply, peak update and write-back, the
// x100 percent scaling, then the output load. No new bin is taken until that
// sequence ends, and the output load waits while the output register stays
// stalled with an earlier result. Bins at or above the used range are dropped
// and produce no word. The peak store comes out of reset as all zero through
// per-bar valid bits, so there is no clearing pass. Configuration sits on a
// small APB-style port (bar_count_log2 at 0x0, the bar gain at 0x4); only
// write it while no bar is in flight.
// ----------------------------------------------------------------------------
module spectrum_bar_peak_hold_unit import sbph_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // bin input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [BIN_W-1:0]   in_bin_index,
  input  wire logic [MAG_W-1:0]   in_magnitude,
  // bar results
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [BAR_W-1:0]        out_bar_number,
  output logic [LEVEL_W-1:0]      out_bar_level,
  output logic [LEVEL_W-1:0]      out_peak_level,
  output logic [BPCT_W-1:0]       out_bar_percent,
  output logic [PPCT_W-1:0]       out_peak_percent,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [KLOG_W-1:0]  bar_log2_r;
  logic [SCALE_W-1:0] scale_r;
  logic               cfg_wr;
  logic               cfg_sel;

  sbph_cmd_t  cmd;
  sbph_stat_t stat;

  // Registers sit on word boundaries; only bit 2 picks one of the two.
  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_log2_r <= KLOG_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_BAR_LOG2) bar_log2_r <= pwdata[KLOG_W-1:0];
      if (cfg_sel == REG_SCALE)    scale_r    <= pwdata[SCALE_W-1:0];
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_BAR_LOG2: prdata = 32'(bar_log2_r);
      REG_SCALE:    prdata = 32'(scale_r);
      default:      prdata = '0;
    endcase
  end

  // Sequencer: stalls input while a closing bin is in flight.
  sbph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Group maximum, peak store and output register.
  sbph_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .bar_log2         (bar_log2_r),
    .scale            (scale_r),
    .in_bin_index     (in_bin_index),
    .in_magnitude     (in_magnitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bar_number   (out_bar_number),
    .out_bar_level    (out_bar_level),
    .out_peak_level   (out_peak_level),
    .out_bar_percent  (out_bar_percent),
    .out_peak_percent (out_peak_percent)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sbph_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbph_checker
// Port-level checks for the spectrum bar meter, bound to the top level.
// ----------------------------------------------------------------------------
module sbph_checker import sbph_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [BIN_W-1:0]   in_bin_index,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [BAR_W-1:0]   out_bar_number,
  input wire logic [LEVEL_W-1:0] out_bar_level,
  input wire logic [LEVEL_W-1:0] out_peak_level,
  input wire logic [BPCT_W-1:0]  out_bar_percent,
  input wire logic [PPCT_W-1:0]  out_peak_percent
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bar_number) &&
                               $stable(out_bar_level) && $stable(out_peak_level) &&
                               $stable(out_bar_percent) && $stable(out_peak_percent))
    else $error("result word changed while stalled");

  // dropped bins never stall the stream
  a_unused_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_bin_index >= BIN_W'(USED_BINS)) |=> !in_stall)
    else $error("stall after an unused bin");

  a_peak_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_percent <= PERCENT_CAP)
    else $error("peak percent above cap");

  a_bar_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bar_percent <= BPCT_W'(200))
    else $error("bar percent out of range");

endmodule

bind spectrum_bar_peak_hold_unit sbph_checker u_sbph_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for spectrum_bar_peak_hold_unit. Bin words are queued
// by the main sequence and streamed in by a clocked driver; a clocked monitor
// checks every bar word against a bar/peak predictor updated at acceptance.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbph_pkg::*;

  // generous run limit and post-traffic drain for a closing word in flight
  localparam int LIMIT_NS     = 2_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MODE_WORDS   = 440;

  typedef struct packed {
    logic [BIN_W-1:0] bin_no;
    logic [MAG_W-1:0] mag;
  } bin_word_t;

  typedef struct packed {
    logic [BAR_W-1:0]   bar_no;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak;
    logic [BPCT_W-1:0]  bar_pct;
    logic [PPCT_W-1:0]  peak_pct;
  } bar_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [BIN_W-1:0]   in_bin_index = '0;
  logic [MAG_W-1:0]   in_magnitude = '0;

  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [BAR_W-1:0]   out_bar_number;
  logic [LEVEL_W-1:0] out_bar_level;
  logic [LEVEL_W-1:0] out_peak_level;
  logic [BPCT_W-1:0]  out_bar_percent;
  logic [PPCT_W-1:0]  out_peak_percent;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [2:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  spectrum_bar_peak_hold_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_bin_index     (in_bin_index),
    .in_magnitude     (in_magnitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bar_number   (out_bar_number),
    .out_bar_level    (out_bar_level),
    .out_peak_level   (out_peak_level),
    .out_bar_percent  (out_bar_percent),
    .out_peak_percent (out_peak_percent),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bar/peak predictor state: own copy of registers, running max, peak hold
  // --------------------------------------------------------------------------
  logic [KLOG_W-1:0]  cfg_log2  = KLOG_RST;
  logic [SCALE_W-1:0] cfg_scale = SCALE_RST;
  logic [MAG_W-1:0]   run_max   = '0;
  logic [LEVEL_W-1:0] peak_hold [MAX_BARS];

  bin_word_t bin_q [$];   // bin words waiting to be driven
  bar_word_t bar_q [$];   // bar words the block still owes us

  int send_idle  = 15;    // percent of cycles the bin source idles
  int recv_idle  = 50;    // percent of cycles the bar sink stalls
  int used_words = 0;     // queued words inside the used bin range
  int mismatches = 0;
  bit word_taken = 1'b0;
  bin_word_t next_word;

  initial begin
    foreach (peak_hold[i]) peak_hold[i] = '0;
  end

  // Bins per bar; the log2 register clamps to 1..8 and a group is never
  // smaller than one bin.
  function automatic int unsigned group_len();
    int unsigned k;
    int unsigned n;
    k = cfg_log2;
    if (k < KLOG_MIN) k = KLOG_MIN;
    if (k > KLOG_MAX) k = KLOG_MAX;
    n = USED_BINS >> k;
    return (n == 0) ? 1 : n;
  endfunction

  // Apply one accepted bin word; queue a bar word when it closes a bar.
  task automatic update_bar(input logic [BIN_W-1:0] bin_no, input logic [MAG_W-1:0] mag);
    int unsigned size;
    int unsigned pos;
    int unsigned bar_idx;
    int unsigned level;
    int unsigned peak;
    int unsigned pct;
    bar_word_t w;
    if (bin_no >= USED_BINS) return;   // unused bin: no state change
    size = group_len();
    pos  = bin_no % size;
    // first bin of a group reloads the max, out-of-order bins just join
    if (pos == 0 || mag > run_max) run_max = mag;
    if (pos != size - 1) return;
    bar_idx = bin_no / size;
    if (bar_idx >= MAX_BARS) return;
    level = (run_max * cfg_scale) & 32'hffff;
    peak  = peak_hold[bar_idx];
    if (peak <= level) peak = level;
    else if (peak > PEAK_DECAY) peak = peak - PEAK_DECAY;
    else peak = 0;                     // decay floors at zero
    peak_hold[bar_idx] = LEVEL_W'(peak);
    pct = (peak * 100) / FULL_SCALE;
    if (pct > PERCENT_CAP) pct = PERCENT_CAP;
    w.bar_no   = BAR_W'(bar_idx);
    w.level    = LEVEL_W'(level);
    w.peak     = LEVEL_W'(peak);
    w.bar_pct  = BPCT_W'((level * 100) / FULL_SCALE);
    w.peak_pct = PPCT_W'(pct);
    bar_q.push_back(w);
  endtask

  // --------------------------------------------------------------------------
  // Bin driver: inputs change on the falling edge, acceptance seen on rising
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      update_bar(in_bin_index, in_magnitude);
      word_taken = 1'b1;
    end
  end

  // a stalled word holds its payload; a new one goes out only after acceptance
  always @(negedge clk) begin
    if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (rst_n && bin_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        next_word = bin_q.pop_front();
        in_valid     <= 1'b1;
        in_bin_index <= next_word.bin_no;
        in_magnitude <= next_word.mag;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // bar sink back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // --------------------------------------------------------------------------
  // Bar monitor: compare each accepted bar word with the oldest prediction
  // --------------------------------------------------------------------------
  bar_word_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bar_q.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected bar word bar=%0d level=%0d peak=%0d",
                   out_bar_number, out_bar_level, out_peak_level);
        mismatches++;
      end else begin
        want = bar_q.pop_front();
        if (out_bar_number !== want.bar_no || out_bar_level !== want.level ||
            out_peak_level !== want.peak || out_bar_percent !== want.bar_pct ||
            out_peak_percent !== want.peak_pct) begin
          if (mismatches < 10)
            $display("tb: mismatch exp bar=%0d lvl=%0d pk=%0d b%%=%0d p%%=%0d",
                     want.bar_no, want.level, want.peak, want.bar_pct, want.peak_pct,
                     " got bar=%0d lvl=%0d pk=%0d b%%=%0d p%%=%0d",
                     out_bar_number, out_bar_level, out_peak_level,
                     out_bar_percent, out_peak_percent);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_word(input logic [BIN_W-1:0] bin_no, input logic [MAG_W-1:0] mag);
    bin_word_t w;
    w.bin_no = bin_no;
    w.mag    = mag;
    bin_q.push_back(w);
    if (bin_no < USED_BINS) used_words++;
  endtask

  // magnitudes biased toward the extremes; 257 * 255 lands on full 16-bit level
  function automatic logic [MAG_W-1:0] rand_mag();
    case ($urandom_range(7))
      0:       return '0;
      1:       return MAG_W'(15'h7fff);
      2:       return MAG_W'($urandom_range(3));
      3:       return MAG_W'(257);
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // Wait until every queued word is in and every bar word is out, then let
  // a possibly busy non-closing word drain before touching the registers.
  task automatic settle();
    while (bin_q.size() != 0 || in_valid || bar_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (idx == REG_BAR_LOG2) ? 32'hf : 32'hff;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_BAR_LOG2) cfg_log2 = val[KLOG_W-1:0];
    else cfg_scale = val[SCALE_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (val & mask)) begin
      if (mismatches < 10)
        $display("tb: register %0d read back %0h, wrote %0h", idx, got & mask, val & mask);
      mismatches++;
    end
  endtask

  // One random register setting followed by a mostly ascending run of bins
  // over a few bars, salted with noise bins, unused bins and dropped bins.
  task automatic random_setting();
    int unsigned k;
    int unsigned s;
    int unsigned size;
    int unsigned groups;
    int unsigned start;
    int unsigned last;
    int unsigned roll;
    settle();
    // mostly small groups; clamped and one-bar-per-128-bin settings now and then
    case ($urandom_range(9))
      0, 1, 2, 3: k = $urandom_range(5, 8);
      4, 5:       k = $urandom_range(9, 15);
      6, 7, 8:    k = $urandom_range(2, 4);
      default:    k = $urandom_range(0, 1);
    endcase
    case ($urandom_range(5))
      0:       s = 0;
      1:       s = 255;
      default: s = $urandom_range(255);
    endcase
    write_reg(REG_BAR_LOG2, k);
    write_reg(REG_SCALE, s);
    size   = group_len();
    groups = (size >= 64) ? 1 : $urandom_range(2, 128 / size);
    start  = $urandom_range(0, USED_BINS / size - 1) * size;
    last   = start + groups * size;
    if (last > USED_BINS) last = USED_BINS;
    for (int unsigned b = start; b < last; b++) begin
      roll = $urandom_range(99);
      if (roll < 5) add_word(BIN_W'($urandom_range(511)), rand_mag());
      else if (roll < 9) add_word(BIN_W'($urandom_range(256, 511)), rand_mag());
      if (roll < 9 || roll >= 12) add_word(BIN_W'(b), rand_mag());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one bin per bar, full gain
    add_word(9'd0, 15'd257);       // level 65535, peak percent clamps at 100
    add_word(9'd0, 15'd0);         // peak decays by 255
    add_word(9'd1, 15'd1);         // level 255
    add_word(9'd1, 15'd0);         // peak of 255 floors to zero
    add_word(9'd2, 15'd2);
    add_word(9'd2, 15'd0);
    add_word(9'd2, 15'd0);
    add_word(9'd255, 15'h7fff);    // level wraps modulo 65536
    add_word(9'd256, 15'h7fff);    // unused bins are dropped
    add_word(9'd511, 15'h7fff);
    add_word(9'd3, 15'h1234);
    settle();

    // log2 above the top clamps to one bin per bar; zero gain
    write_reg(REG_BAR_LOG2, 32'd9);
    write_reg(REG_SCALE, 32'd0);
    add_word(9'd4, 15'h7fff);
    add_word(9'd0, 15'd0);
    settle();

    // log2 of zero counts as one: two bars of 128 bins, unit gain
    write_reg(REG_BAR_LOG2, 32'd0);
    write_reg(REG_SCALE, 32'd1);
    add_word(9'd0, 15'd5);         // group start loads the max
    add_word(9'd127, 15'd7);       // closes bar 0 early
    add_word(9'd128, 15'd9);
    add_word(9'd200, 15'd100);
    add_word(9'd130, 15'd3);       // out-of-order bin joins its group
    add_word(9'd255, 15'd0);       // closes bar 1 with max 100
    add_word(9'd127, 15'd1);       // closes bar 0 again, max carries over
    add_word(9'd300, 15'h5555);

    // random part: three idling profiles
    for (int mode = 0; mode < 3; mode++) begin
      int target;
      target = used_words + MODE_WORDS;
      case (mode)
        0:       begin send_idle = 15; recv_idle = 50; end
        1:       begin send_idle = 50; recv_idle = 15; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      while (used_words < target) random_setting();
    end
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #LIMIT_NS;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sbph_pkg.sv
hw/rtl/sbph_ctrl.sv
hw/rtl/sbph_datapath.sv
hw/rtl/spectrum_bar_peak_hold_unit.sv
hw/rtl/sbph_checker.sv
sim/testbench.sv
